// ===== src/pwmt_pkg.sv =====
// Shared definitions for the four-channel PWM timer register block.
// Holds parameter defaults, item kind codes and the register map offsets.
// No dependencies.
package pwmt_pkg;

    // Parameter defaults.
    localparam int CHANNELS_DEFAULT   = 4;
    localparam int COUNT_BITS_DEFAULT = 32;

    // Kind of an input item (the unused code changes nothing).
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } kind_t;

    // Register map.
    localparam logic [11:0] GLOBAL_OFFSET = 12'h000;
    localparam logic [3:0]  SUB_CONTROL   = 4'h0;
    localparam logic [3:0]  SUB_PERIOD    = 4'h4;
    localparam logic [3:0]  SUB_DUTY      = 4'h8;
    localparam logic [3:0]  SUB_COUNTER   = 4'hC;

    // Bit positions in the global register.
    localparam int DONE_SHIFT = 4;

    // Control register bits.
    localparam int CTRL_BITS  = 3;
    localparam int CTRL_EN    = 0;
    localparam int CTRL_POL   = 1;
    localparam int CTRL_INTIE = 2;

    localparam int REG_BITS = 32;

endpackage

// ===== src/multi_channel_pwm_timer_registers_top.sv =====
// Top level of the PWM timer register block: input register, register file,
// per-channel counters and result register. Depends on pwmt_pkg.
//
// Each transaction on the slave side is a one-microsecond tick, a register
// read or a register write, and gives exactly one transaction on the master
// side carrying the read data (zero for ticks, writes and bad offsets) and the
// interrupt level after the item. An item waits in the input register and moves
// into the result register when that is empty or being taken; the block
// takes a new item every clock, limited only by the master side taking
// results. Register map: 0x00 global (bits 3..0 enables, bits 7..4 done,
// write one to clear), 0x10 + n*0x10 control (EN, POL, INTIE), +0x4 period,
// +0x8 duty, +0xC counter (read only). A period write is compared on every
// tick, so a counter already past it wraps on the next tick.
module multi_channel_pwm_timer_registers_top #(
    parameter int CHANNELS   = pwmt_pkg::CHANNELS_DEFAULT,
    parameter int COUNT_BITS = pwmt_pkg::COUNT_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [11:0] offset, [43:12] write_data, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] read_data, [32] irq, rest zero
);

    localparam int RB = pwmt_pkg::REG_BITS;
    localparam int CB = pwmt_pkg::CTRL_BITS;

    // Input register.
    logic          in_valid_reg;
    logic [1:0]    in_kind_reg;
    logic [11:0]   in_offset_reg;
    logic [RB-1:0] in_wdata_reg;

    // Result register.
    logic          out_valid_reg;
    logic [RB-1:0] out_rdata_reg;
    logic          out_irq_reg;

    // Channel state.
    logic [CB-1:0]         control_reg [CHANNELS];
    logic [RB-1:0]         period_reg  [CHANNELS];
    logic [RB-1:0]         duty_reg    [CHANNELS];
    logic [COUNT_BITS-1:0] counter_reg [CHANNELS];
    logic [CHANNELS-1:0]   done_reg;

    logic [CB-1:0]         control_next [CHANNELS];
    logic [RB-1:0]         period_next  [CHANNELS];
    logic [RB-1:0]         duty_next    [CHANNELS];
    logic [COUNT_BITS-1:0] counter_next [CHANNELS];
    logic [CHANNELS-1:0]   done_next;
    logic [RB-1:0]         rdata_next;
    logic                  irq_next;

    logic proc_fire;
    logic in_fire;

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign in_fire   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_irq_reg, out_rdata_reg};

    always_comb
    begin
        logic          global_hit;
        logic          chan_hit;
        logic          was_en;
        logic          now_en;
        logic          zero_period;
        logic [RB-1:0] cnt_ext;
        logic [RB-1:0] cnt_value;
        logic [CHANNELS-1:0] irq_terms;

        control_next = control_reg;
        period_next  = period_reg;
        duty_next    = duty_reg;
        counter_next = counter_reg;
        done_next    = done_reg;
        rdata_next   = '0;
        irq_terms    = '0;
        global_hit   = (in_offset_reg == pwmt_pkg::GLOBAL_OFFSET);

        for (int c = 0; c < CHANNELS; c++)
        begin
            chan_hit    = (in_offset_reg[11:4] == 8'(c + 1));
            was_en      = control_reg[c][pwmt_pkg::CTRL_EN];
            now_en      = in_wdata_reg[pwmt_pkg::CTRL_EN];
            zero_period = (period_reg[c] == '0);
            cnt_ext     = RB'(counter_reg[c]);
            // An enabled channel without a period reads its counter as zero.
            cnt_value   = (was_en && zero_period) ? '0 : cnt_ext;

            unique case (in_kind_reg)
                pwmt_pkg::KIND_TICK:
                begin
                    if (was_en && !zero_period)
                    begin
                        if (cnt_ext >= period_reg[c] || counter_reg[c] == '1)
                        begin
                            counter_next[c] = '0;
                            done_next[c]    = 1'b1;
                        end
                        else
                        begin
                            counter_next[c] = COUNT_BITS'(counter_reg[c] + 1'b1);
                        end
                    end
                end
                pwmt_pkg::KIND_READ:
                begin
                    if (global_hit)
                    begin
                        rdata_next[c] = was_en;
                        rdata_next[c + pwmt_pkg::DONE_SHIFT] = done_reg[c];
                    end
                    else if (chan_hit)
                    begin
                        unique case (in_offset_reg[3:0])
                            pwmt_pkg::SUB_CONTROL: rdata_next = RB'(control_reg[c]);
                            pwmt_pkg::SUB_PERIOD:  rdata_next = period_reg[c];
                            pwmt_pkg::SUB_DUTY:    rdata_next = duty_reg[c];
                            pwmt_pkg::SUB_COUNTER: rdata_next = cnt_value;
                            default:               rdata_next = '0;
                        endcase
                    end
                end
                pwmt_pkg::KIND_WRITE:
                begin
                    if (global_hit)
                    begin
                        if (in_wdata_reg[c + pwmt_pkg::DONE_SHIFT])
                        begin
                            done_next[c] = 1'b0;
                        end
                    end
                    else if (chan_hit)
                    begin
                        unique case (in_offset_reg[3:0])
                            pwmt_pkg::SUB_CONTROL:
                            begin
                                if (!was_en && now_en)
                                begin
                                    counter_next[c] = '0;
                                    done_next[c]    = 1'b0;
                                end
                                else if (was_en && !now_en)
                                begin
                                    // Freeze at the value the counter reads as.
                                    counter_next[c] = COUNT_BITS'(cnt_value);
                                end
                                control_next[c] = in_wdata_reg[CB-1:0];
                            end
                            pwmt_pkg::SUB_PERIOD: period_next[c] = in_wdata_reg;
                            pwmt_pkg::SUB_DUTY:   duty_next[c]   = in_wdata_reg;
                            default:
                            begin
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase

            irq_terms[c] = done_next[c] && control_next[c][pwmt_pkg::CTRL_INTIE];
        end

        irq_next = |irq_terms;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_irq_reg   <= 1'b0;
            done_reg      <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                control_reg[c] <= '0;
                period_reg[c]  <= '0;
                duty_reg[c]    <= '0;
                counter_reg[c] <= '0;
            end
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc_fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (proc_fire)
            begin
                out_valid_reg <= 1'b1;
                out_irq_reg   <= irq_next;
                control_reg   <= control_next;
                period_reg    <= period_next;
                duty_reg      <= duty_next;
                counter_reg   <= counter_next;
                done_reg      <= done_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_kind_reg   <= s_tuser;
            in_offset_reg <= s_tdata[11:0];
            in_wdata_reg  <= s_tdata[43:12];
        end
        if (proc_fire)
        begin
            out_rdata_reg <= rdata_next;
        end
    end

endmodule

// ===== sim/tb_multi_channel_pwm_timer_registers_top.sv =====
// Self-checking testbench for the four-channel PWM timer register block.
// Drives ticks, register reads and register writes and checks every result.
// Depends on pwmt_pkg and multi_channel_pwm_timer_registers_top.
module tb_multi_channel_pwm_timer_registers_top;

    timeunit 1ns;
    timeprecision 1ps;

    import pwmt_pkg::*;

    localparam int CHANNELS   = CHANNELS_DEFAULT;
    localparam int COUNT_BITS = COUNT_BITS_DEFAULT;
    localparam logic [REG_BITS-1:0] CNT_MASK = {REG_BITS{1'b1}} >> (REG_BITS - COUNT_BITS);
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 1050;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 400;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [1:0]          kind;
        logic [11:0]         offset;
        logic [REG_BITS-1:0] write_data;
    } bus_item_t;

    typedef struct packed {
        logic [REG_BITS-1:0] read_data;
        logic                irq;
    } reg_reply_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // [11:0] offset, [43:12] write_data, rest zero
    logic [1:0]  s_tuser;   // [1:0] kind
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] read_data, [32] irq, rest zero

    // Shadow copy of the timer state.
    logic [CTRL_BITS-1:0] chan_ctl  [CHANNELS] = '{default: '0};
    logic [REG_BITS-1:0]  chan_per  [CHANNELS] = '{default: '0};
    logic [REG_BITS-1:0]  chan_duty [CHANNELS] = '{default: '0};
    logic [REG_BITS-1:0]  chan_cnt  [CHANNELS] = '{default: '0};
    logic                 chan_done [CHANNELS] = '{default: 1'b0};

    bus_item_t  bus_items[$];
    reg_reply_t expected_replies[$];
    bus_item_t  tx_next;
    reg_reply_t want;

    bit in_taken     = 1'b0;
    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;
    bit rx_hold_done = 1'b0;
    int tx_gap       = 0;
    int rx_stall     = 0;
    int idle_cycles  = 0;
    int mismatch_count  = 0;
    int replies_checked = 0;
    int irq_high_count  = 0;
    int kind_count [4]  = '{default: 0};

    multi_channel_pwm_timer_registers_top #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [11:0] chan_reg(int ch, logic [3:0] sub);
        return 12'h010 + 12'(ch * 16) + 12'(sub);
    endfunction

    // An enabled channel with a zero period shows zero.
    function automatic logic [REG_BITS-1:0] counter_view(int c);
        if (chan_ctl[c][CTRL_EN] && chan_per[c] == '0)
            return '0;
        return chan_cnt[c] & CNT_MASK;
    endfunction

    function automatic reg_reply_t timer_apply(bus_item_t it);
        reg_reply_t r;
        logic [REG_BITS-1:0] cnt;
        logic [11:0] rel;
        logic [3:0] sub;
        logic hit;
        logic was_on;
        int ch;
        r   = '0;
        rel = it.offset - 12'h010;
        hit = (it.offset >= 12'h010) && (int'(rel >> 4) < CHANNELS);
        ch  = hit ? int'(rel >> 4) : 0;
        sub = it.offset[3:0];
        case (it.kind)
            KIND_TICK:
                for (int c = 0; c < CHANNELS; c++)
                begin
                    cnt = chan_cnt[c] & CNT_MASK;
                    if (chan_ctl[c][CTRL_EN] && chan_per[c] != '0)
                    begin
                        if (cnt >= chan_per[c] || cnt == CNT_MASK)
                        begin
                            chan_cnt[c]  = '0;
                            chan_done[c] = 1'b1;
                        end
                        else
                            chan_cnt[c] = cnt + 1;
                    end
                end
            KIND_READ:
                if (it.offset == GLOBAL_OFFSET)
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        r.read_data[c]              = chan_ctl[c][CTRL_EN];
                        r.read_data[c + DONE_SHIFT] = chan_done[c];
                    end
                end
                else if (hit)
                begin
                    case (sub)
                        SUB_CONTROL: r.read_data = REG_BITS'(chan_ctl[ch]);
                        SUB_PERIOD:  r.read_data = chan_per[ch];
                        SUB_DUTY:    r.read_data = chan_duty[ch];
                        SUB_COUNTER: r.read_data = counter_view(ch);
                        default:     r.read_data = '0;
                    endcase
                end
            KIND_WRITE:
                if (it.offset == GLOBAL_OFFSET)
                begin
                    for (int c = 0; c < CHANNELS; c++)
                        if (it.write_data[c + DONE_SHIFT])
                            chan_done[c] = 1'b0;
                end
                else if (hit)
                begin
                    case (sub)
                        SUB_CONTROL:
                        begin
                            was_on = chan_ctl[ch][CTRL_EN];
                            if (!was_on && it.write_data[CTRL_EN])
                            begin
                                chan_cnt[ch]  = '0;
                                chan_done[ch] = 1'b0;
                            end
                            else if (was_on && !it.write_data[CTRL_EN])
                                chan_cnt[ch] = counter_view(ch);
                            chan_ctl[ch] = it.write_data[CTRL_BITS-1:0];
                        end
                        SUB_PERIOD: chan_per[ch]  = it.write_data;
                        SUB_DUTY:   chan_duty[ch] = it.write_data;
                        default:    ;
                    endcase
                end
            default: ;
        endcase
        for (int c = 0; c < CHANNELS; c++)
            if (chan_done[c] && chan_ctl[c][CTRL_INTIE])
                r.irq = 1'b1;
        return r;
    endfunction

    task automatic add_item(logic [1:0] kind, logic [11:0] offset, logic [REG_BITS-1:0] data);
        bus_items.push_back('{kind: kind, offset: offset, write_data: data});
    endtask

    // Mostly mapped registers, now and then any offset at all.
    function automatic logic [11:0] random_reg_offset();
        int slot;
        slot = $urandom_range(0, CHANNELS * 4 + 2);
        if (slot == 0)
            return GLOBAL_OFFSET;
        if (slot > CHANNELS * 4)
            return 12'($urandom);
        return chan_reg((slot - 1) / 4, 4'(((slot - 1) % 4) * 4));
    endfunction

    function automatic int pick_gap(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sender: a new transaction is presented only once the last one was taken.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (tx_gap > 0)
            begin
                s_tvalid <= 1'b0;
                tx_gap--;
            end
            else if (bus_items.size() != 0)
            begin
                tx_next = bus_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0, tx_next.write_data, tx_next.offset};
                s_tuser  <= tx_next.kind;
                if ($urandom_range(0, 99) == 0)
                    tx_steady = !tx_steady;
                tx_gap = pick_gap(tx_steady);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver, with one long hold-off that backs the block up into its input.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 199) == 0)
                rx_steady = !rx_steady;
            if (!rx_hold_done && replies_checked >= HOLD_AFTER)
            begin
                rx_hold_done = 1'b1;
                rx_stall     = HOLD_CYCLES;
            end
            if (rx_stall > 0)
            begin
                m_tready <= 1'b0;
                rx_stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                rx_stall = pick_gap(rx_steady);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual %h", $time, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (m_tdata[31:0] !== want.read_data)
                    begin
                        $display("%0t: read_data mismatch, expected %h, actual %h",
                                 $time, want.read_data, m_tdata[31:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[32] !== want.irq)
                    begin
                        $display("%0t: irq mismatch, expected %b, actual %b",
                                 $time, want.irq, m_tdata[32]);
                        mismatch_count++;
                    end
                    replies_checked++;
                    if (m_tdata[32] === 1'b1)
                        irq_high_count++;
                end
            end
            in_taken = s_tvalid && s_tready;
            if (in_taken)
            begin
                expected_replies.push_back(timer_apply('{kind: s_tuser,
                                                         offset: s_tdata[11:0],
                                                         write_data: s_tdata[43:12]}));
                kind_count[s_tuser]++;
            end
        end
    end

    // Cycles without any transaction while work is outstanding.
    always @(posedge clk)
    begin
        if (rst_n && (bus_items.size() != 0 || s_tvalid || expected_replies.size() != 0))
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, no transaction for %0d cycles",
                         $time, WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int pick;
        logic [11:0] off;
        logic [REG_BITS-1:0] data;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;

        // Directed part: wrap and done, zero period, enable edges,
        // period shrink, ignored writes and bad offsets.
        add_item(KIND_READ,  GLOBAL_OFFSET, '0);
        add_item(KIND_WRITE, chan_reg(0, SUB_PERIOD), 32'd2);
        add_item(KIND_WRITE, chan_reg(0, SUB_CONTROL), 32'hFFFF_FFFF);
        repeat (4)
            add_item(KIND_TICK, '0, '0);
        add_item(KIND_READ,  GLOBAL_OFFSET, '0);
        add_item(KIND_READ,  chan_reg(0, SUB_CONTROL), '0);
        add_item(KIND_WRITE, chan_reg(0, SUB_COUNTER), 32'hFFFF_FFFF);
        add_item(KIND_READ,  chan_reg(0, SUB_COUNTER), '0);
        add_item(KIND_WRITE, chan_reg(0, SUB_PERIOD), '0);
        add_item(KIND_READ,  chan_reg(0, SUB_COUNTER), '0);
        add_item(KIND_WRITE, chan_reg(0, SUB_CONTROL), '0);
        add_item(KIND_WRITE, chan_reg(1, SUB_PERIOD), 32'd5);
        add_item(KIND_WRITE, chan_reg(1, SUB_CONTROL), 32'd1);
        add_item(KIND_TICK,  12'hFFF, 32'hFFFF_FFFF);
        add_item(KIND_TICK,  '0, '0);
        // A period below the running count makes it wrap on the next tick.
        add_item(KIND_WRITE, chan_reg(1, SUB_PERIOD), 32'd1);
        add_item(KIND_TICK,  '0, '0);
        add_item(KIND_WRITE, chan_reg(1, SUB_CONTROL), '0);
        add_item(KIND_READ,  chan_reg(1, SUB_COUNTER), '0);
        add_item(KIND_WRITE, GLOBAL_OFFSET, 32'h0000_00F0);
        add_item(KIND_WRITE, chan_reg(CHANNELS, SUB_CONTROL), 32'hFFFF_FFFF);
        add_item(KIND_READ,  chan_reg(CHANNELS, SUB_CONTROL), '0);
        add_item(KIND_READ,  12'h004, '0);
        add_item(KIND_READ,  12'h011, '0);
        add_item(KIND_READ,  12'hFFF, '0);
        add_item(KIND_UNUSED, 12'hFFF, 32'hFFFF_FFFF);
        add_item(KIND_WRITE, chan_reg(3, SUB_DUTY), 32'hFFFF_FFFF);
        add_item(KIND_READ,  chan_reg(3, SUB_DUTY), '0);

        // Random part: ticks interleaved with accesses that keep channels
        // enabled on short periods so that wraps and interrupts keep coming.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                add_item(KIND_TICK, 12'($urandom), $urandom);
            else if (pick < 68)
                add_item(KIND_READ, random_reg_offset(), $urandom);
            else if (pick < 95)
            begin
                off  = random_reg_offset();
                data = $urandom;
                if (off == GLOBAL_OFFSET)
                begin
                    if ($urandom_range(0, 1) == 0)
                        data[DONE_SHIFT +: CHANNELS] = '0;
                end
                else if (off[3:0] == SUB_CONTROL)
                    data[CTRL_EN] = ($urandom_range(0, 3) != 0);
                else if (off[3:0] == SUB_PERIOD)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7)
                        data = $urandom_range(0, 6);
                    else if (pick < 9)
                        data = $urandom_range(7, 40);
                end
                add_item(KIND_WRITE, off, data);
            end
            else
                add_item(KIND_UNUSED, 12'($urandom), $urandom);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (bus_items.size() != 0 || s_tvalid || expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d ticks, %0d reads, %0d writes and %0d items of the unused kind.",
                 kind_count[KIND_TICK], kind_count[KIND_READ], kind_count[KIND_WRITE],
                 kind_count[KIND_UNUSED]);
        $display("Checked %0d results, %0d of them with the interrupt raised.",
                 replies_checked, irq_high_count);
        if (expected_replies.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, expected_replies.size());
        if (mismatch_count == 0 && expected_replies.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
